/* sv/pwmc_pkg.sv */
package pwmc_pkg;

  // timestamp, clock register, duty and capture port widths
  localparam int STAMP_W  = 24;
  localparam int CLK_W    = 27;
  localparam int DUTY_W   = 7;
  localparam int CAP_W    = 16;
  // high time times 100 fits in this many bits when high time < period
  localparam int NUM_W    = STAMP_W + DUTY_W;
  localparam int ITER_W   = 5;

  localparam logic [DUTY_W-1:0] PCT_FULL    = DUTY_W'(100);
  localparam logic [ITER_W-1:0] FREQ_ITERS  = ITER_W'(CLK_W);
  localparam logic [ITER_W-1:0] DUTY_ITERS  = ITER_W'(DUTY_W);
  localparam logic [CLK_W-1:0]  CLK_RST     = CLK_W'(8000000);

  // configuration register indexes
  localparam logic CFG_TIMER_CLOCK = 1'b0;
  localparam logic CFG_REARM       = 1'b1;

  // event kinds
  localparam logic OPC_TICK    = 1'b0;
  localparam logic OPC_CAPTURE = 1'b1;

  localparam logic EDGE_RISING  = 1'b0;
  localparam logic EDGE_FALLING = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST_RISE  = 2'd0,
    PH_FALL        = 2'd1,
    PH_SECOND_RISE = 2'd2,
    PH_FINISHED    = 2'd3
  } phase_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

endpackage

/* sv/pwmc_divider.sv */
module pwmc_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pwmc_pkg::div_req_t              req,
  input  logic [pwmc_pkg::STAMP_W-1:0]    den,
  input  logic [pwmc_pkg::STAMP_W-1:0]    rem_init,
  input  logic [pwmc_pkg::CLK_W-1:0]      dividend,
  output logic                            done,
  output logic [pwmc_pkg::CLK_W-1:0]      quotient
);

  localparam logic [pwmc_pkg::ITER_W-1:0] ITER_ONE = pwmc_pkg::ITER_W'(1);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pwmc_pkg::ITER_W-1:0]     cnt_r, cnt_nxt;
  logic [pwmc_pkg::STAMP_W-1:0]    den_r, den_nxt;
  logic [pwmc_pkg::STAMP_W-1:0]    rem_r, rem_nxt;
  logic [pwmc_pkg::CLK_W-1:0]      sh_r, sh_nxt;

  logic [pwmc_pkg::STAMP_W:0]      trial;
  logic [pwmc_pkg::STAMP_W:0]      diff;
  logic                            take;

  // one restoring step: remainder stays below the divisor
  assign trial = {rem_r, sh_r[pwmc_pkg::CLK_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign take  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      den_nxt  = den;
      rem_nxt  = rem_init;
      sh_nxt   = dividend;
    end else if (busy_r) begin
      rem_nxt = take ? diff[pwmc_pkg::STAMP_W-1:0] : trial[pwmc_pkg::STAMP_W-1:0];
      sh_nxt  = {sh_r[pwmc_pkg::CLK_W-2:0], take};
      cnt_nxt = cnt_r - ITER_ONE;
      if (cnt_r == ITER_ONE) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

/* sv/pwm_period_duty_capture.sv */
// channel  dir  handshake          payload
// in_      in   in_valid/in_ready  in_opcode, in_capture_value
// out_     out  out_valid/out_ready next_edge, done_res, period_ticks, frequency_hz,
//                                   duty_percent, status
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a tick or a capture that does not close a measurement goes from idle straight to the output state
// a closing capture passes prep, frequency and duty states: one shared restoring divider runs 27 steps
// for frequency and 7 steps for duty, one quotient bit per cycle
// a zero period goes from prep straight to the output state, a saturated duty skips the duty steps
// in_ready is high only in idle; one finished result may wait in the output register
// synchronous active-low reset clears phase, overflow count and handshake state
module pwm_period_duty_capture #(
  parameter int CAPTURE_BITS  = 16,
  parameter int OVERFLOW_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [pwmc_pkg::CAP_W-1:0]      in_capture_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_next_edge,
  output logic                            out_done_res,
  output logic [pwmc_pkg::STAMP_W-1:0]    out_period_ticks,
  output logic [pwmc_pkg::CLK_W-1:0]      out_frequency_hz,
  output logic [pwmc_pkg::DUTY_W-1:0]     out_duty_percent,
  output logic                            out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [pwmc_pkg::CLK_W-1:0]      cfg_data
);

  localparam int VALID_BITS = (CAPTURE_BITS < pwmc_pkg::CAP_W) ? CAPTURE_BITS : pwmc_pkg::CAP_W;
  localparam logic [pwmc_pkg::CAP_W-1:0] CAP_MASK =
    pwmc_pkg::CAP_W'((33'(1) << VALID_BITS) - 33'(1));
  localparam logic [OVERFLOW_BITS-1:0] OVF_ONE = OVERFLOW_BITS'(1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_PREP     = 6'b000010,
    ST_FREQ     = 6'b000100,
    ST_DUTY_SET = 6'b001000,
    ST_DUTY     = 6'b010000,
    ST_OUT      = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  pwmc_pkg::phase_t               phase_r, phase_nxt;
  logic [OVERFLOW_BITS-1:0]       ovf_r, ovf_nxt;
  logic [pwmc_pkg::STAMP_W-1:0]   first_r, first_nxt;
  logic [pwmc_pkg::STAMP_W-1:0]   fall_r, fall_nxt;
  logic [pwmc_pkg::STAMP_W-1:0]   stamp_r, stamp_nxt;
  logic [pwmc_pkg::STAMP_W-1:0]   period_r, period_nxt;
  logic [pwmc_pkg::STAMP_W-1:0]   high_r, high_nxt;
  logic [pwmc_pkg::CLK_W-1:0]     freq_r, freq_nxt;
  logic [pwmc_pkg::DUTY_W-1:0]    duty_r, duty_nxt;
  logic                           status_r, status_nxt;
  logic                           calc_r, calc_nxt;
  logic                           nedge_r, nedge_nxt;
  logic [pwmc_pkg::CLK_W-1:0]     clk_hz_r;
  logic                           rearm_r;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_nedge_r;
  logic                           out_done_r;
  logic [pwmc_pkg::STAMP_W-1:0]   out_period_r;
  logic [pwmc_pkg::CLK_W-1:0]     out_freq_r;
  logic [pwmc_pkg::DUTY_W-1:0]    out_duty_r;
  logic                           out_status_r;
  logic                           out_load;

  logic                           in_fire;
  logic [63:0]                    ovf_wide;
  logic [pwmc_pkg::STAMP_W-1:0]   stamp;
  logic [pwmc_pkg::STAMP_W-1:0]   period_diff;
  logic [pwmc_pkg::STAMP_W-1:0]   high_diff;
  logic [pwmc_pkg::NUM_W-1:0]     high_x100;
  pwmc_pkg::phase_t               phase_eff;

  pwmc_pkg::div_req_t             div_req;
  logic [pwmc_pkg::STAMP_W-1:0]   div_den;
  logic [pwmc_pkg::STAMP_W-1:0]   div_rem_init;
  logic [pwmc_pkg::CLK_W-1:0]     div_dividend;
  logic                           div_done;
  logic [pwmc_pkg::CLK_W-1:0]     div_quo;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // timestamp: capture bits plus overflow count above them, modulo 2^24
  assign ovf_wide = 64'(ovf_r) << CAPTURE_BITS;
  assign stamp    = pwmc_pkg::STAMP_W'(in_capture_value & CAP_MASK)
                  + ovf_wide[pwmc_pkg::STAMP_W-1:0];

  assign period_diff = stamp_r - first_r;
  assign high_diff   = fall_r - first_r;
  // 100 = 64 + 32 + 4
  assign high_x100   = (pwmc_pkg::NUM_W'(high_r) << 6) + (pwmc_pkg::NUM_W'(high_r) << 5)
                     + (pwmc_pkg::NUM_W'(high_r) << 2);

  assign phase_eff = (phase_r == pwmc_pkg::PH_FINISHED && rearm_r) ? pwmc_pkg::PH_FIRST_RISE
                                                                   : phase_r;

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    ovf_nxt      = ovf_r;
    first_nxt    = first_r;
    fall_nxt     = fall_r;
    stamp_nxt    = stamp_r;
    period_nxt   = period_r;
    high_nxt     = high_r;
    freq_nxt     = freq_r;
    duty_nxt     = duty_r;
    status_nxt   = status_r;
    calc_nxt     = calc_r;
    nedge_nxt    = nedge_r;
    div_req      = '0;
    div_den      = period_r;
    div_rem_init = '0;
    div_dividend = clk_hz_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          calc_nxt   = 1'b0;
          period_nxt = '0;
          freq_nxt   = '0;
          duty_nxt   = '0;
          status_nxt = 1'b0;
          if (in_opcode == pwmc_pkg::OPC_TICK) begin
            ovf_nxt = ovf_r + OVF_ONE;
          end else begin
            phase_nxt = phase_eff;
            case (phase_eff)
              pwmc_pkg::PH_FIRST_RISE: begin
                first_nxt = stamp;
                phase_nxt = pwmc_pkg::PH_FALL;
              end
              pwmc_pkg::PH_FALL: begin
                fall_nxt  = stamp;
                phase_nxt = pwmc_pkg::PH_SECOND_RISE;
              end
              pwmc_pkg::PH_SECOND_RISE: begin
                stamp_nxt = stamp;
                calc_nxt  = 1'b1;
                phase_nxt = rearm_r ? pwmc_pkg::PH_FIRST_RISE : pwmc_pkg::PH_FINISHED;
              end
              default: begin
              end
            endcase
          end
          nedge_nxt = (phase_nxt == pwmc_pkg::PH_FALL) ? pwmc_pkg::EDGE_FALLING
                                                       : pwmc_pkg::EDGE_RISING;
          state_nxt = calc_nxt ? ST_PREP : ST_OUT;
        end
      end
      ST_PREP: begin
        period_nxt = period_diff;
        high_nxt   = high_diff;
        if (period_diff == '0) begin
          status_nxt = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.iters = pwmc_pkg::FREQ_ITERS;
          div_den       = period_diff;
          state_nxt     = ST_FREQ;
        end
      end
      ST_FREQ: begin
        if (div_done) begin
          freq_nxt  = div_quo;
          state_nxt = ST_DUTY_SET;
        end
      end
      ST_DUTY_SET: begin
        if (high_r >= period_r) begin
          duty_nxt  = pwmc_pkg::PCT_FULL;
          state_nxt = ST_OUT;
        end else begin
          // quotient is below 128, so the top bits start as the remainder
          div_req.start = 1'b1;
          div_req.iters = pwmc_pkg::DUTY_ITERS;
          div_rem_init  = high_x100[pwmc_pkg::NUM_W-1:pwmc_pkg::DUTY_W];
          div_dividend  = {high_x100[pwmc_pkg::DUTY_W-1:0],
                           (pwmc_pkg::CLK_W-pwmc_pkg::DUTY_W)'(0)};
          state_nxt     = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (div_done) begin
          duty_nxt  = div_quo[pwmc_pkg::DUTY_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  pwmc_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .den      (div_den),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= pwmc_pkg::PH_FIRST_RISE;
      ovf_r       <= '0;
      first_r     <= '0;
      fall_r      <= '0;
      out_valid_r <= 1'b0;
      clk_hz_r    <= pwmc_pkg::CLK_RST;
      rearm_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ovf_r       <= ovf_nxt;
      first_r     <= first_nxt;
      fall_r      <= fall_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pwmc_pkg::CFG_TIMER_CLOCK: clk_hz_r <= cfg_data;
          pwmc_pkg::CFG_REARM:       rearm_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
    stamp_r  <= stamp_nxt;
    period_r <= period_nxt;
    high_r   <= high_nxt;
    freq_r   <= freq_nxt;
    duty_r   <= duty_nxt;
    status_r <= status_nxt;
    calc_r   <= calc_nxt;
    nedge_r  <= nedge_nxt;
    if (out_load) begin
      out_nedge_r  <= nedge_r;
      out_done_r   <= calc_r;
      out_period_r <= period_r;
      out_freq_r   <= freq_r;
      out_duty_r   <= duty_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_edge    = out_nedge_r;
  assign out_done_res     = out_done_r;
  assign out_period_ticks = out_period_r;
  assign out_frequency_hz = out_freq_r;
  assign out_duty_percent = out_duty_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_FREQ || state_r == ST_DUTY))
    else $error("divider finished outside a divide state");

  a_no_result_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_period_ticks == '0 && out_frequency_hz == '0
      && out_duty_percent == '0 && !out_status))
    else $error("result fields set without a finished measurement");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty_percent <= pwmc_pkg::PCT_FULL))
    else $error("duty above full scale");

  a_zero_period_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_done_res && out_period_ticks == '0
      && out_frequency_hz == '0 && out_duty_percent == '0))
    else $error("zero period result not forced to zero");
`endif

endmodule
